>>> hdl/hdp_pkg.sv
package hdp_pkg;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int ARITY_W = 4;

    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;
    localparam logic [ARITY_W-1:0] ARITY_MIN   = 4'd2;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2,
        OP_UPDATE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

>>> hdl/hdp_in_if.sv
interface hdp_in_if;
    import hdp_pkg::*;

    logic                    valid;
    logic                    ready;
    op_t                     opcode;
    key_t                    item_value;
    logic [SLOT_W-1:0]       slot_index;

    modport source (output valid, opcode, item_value, slot_index, input ready);
    modport sink (input valid, opcode, item_value, slot_index, output ready);
endinterface

>>> hdl/hdp_out_if.sv
interface hdp_out_if;
    import hdp_pkg::*;

    logic                    valid;
    logic                    ready;
    key_t                    max_value;
    status_t                 status;
    logic [COUNT_W-1:0]      entry_count;

    modport source (output valid, max_value, status, entry_count, input ready);
    modport sink (input valid, max_value, status, entry_count, output ready);
endinterface

>>> hdl/hdp_ram.sv
module hdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/hdp_div.sv
module hdp_div #(
    parameter int NW  = 10,
    parameter int DVW = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [NW-1:0]  quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    quo_reg, quo_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVW:0]     shifted;
    logic             qbit;
    logic [NW:0]      quo_shift;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        qbit      = (shifted >= {1'b0, divisor});
        quo_shift = {quo_reg, qbit};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            rem_next = qbit ? DVW'(shifted - {1'b0, divisor}) : DVW'(shifted);
            quo_next = quo_shift[NW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/d_ary_max_heap_top.sv
// d-ary max-heap priority queue of signed 32-bit keys in one synchronous RAM
// (one write and one registered read port). Items are handled one at a time;
// a new item is taken once the previous result has been transferred out.
// Steps per item: an error only returns its status; peek reads the root;
// extract of the last key reads the root only; extract reads the root and
// the last key and sifts down; insert sifts up; update sifts down and then
// sifts up again from the updated slot. A sift-down level finds the first
// child, reads the children (up to the clamped arity d) and writes; a level
// without children only writes. A sift-up level finds the parent with a
// bit-serial divider at one quotient bit a cycle, then reads it and compares;
// at the root it only writes. Arity writes below 2 act as 2 and above
// MAX_ARITY as MAX_ARITY; write arity only while the block is idle.
module d_ary_max_heap_top #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_ARITY = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hdp_pkg::ARITY_W-1:0] cfg_wdata,
    hdp_in_if.sink                    in_ch,
    hdp_out_if.source                 out_ch
);
    import hdp_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = $clog2(MAX_ARITY + 1);
    localparam int FW = AW + DW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PEEK,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_START,
        S_DN_CHK,
        S_DN_SCAN,
        S_DN_DEC,
        S_UP_START,
        S_UP_DIV,
        S_UP_CMP
    } state_t;

    state_t            state_reg, state_next;
    logic [ARITY_W-1:0] arity_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    key_t              cur_reg, cur_next;
    logic [FW-1:0]     first_reg, first_next;
    logic [DW-1:0]     k_reg, k_next;
    key_t              best_key_reg, best_key_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [AW-1:0]     slot_reg, slot_next;
    key_t              slot_key_reg, slot_key_next;
    logic              upd_reg, upd_next;
    logic              moved_reg, moved_next;
    logic              out_valid_reg, out_valid_next;
    key_t              max_reg, max_next;
    status_t           status_reg, status_next;

    logic [DW-1:0]     d_eff;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    key_t              ram_wdata;
    logic [KEY_W-1:0]  ram_rdata_raw;
    key_t              ram_rdata;
    logic              div_start, div_done;
    logic [AW-1:0]     div_q;
    logic [FW-1:0]     child_idx, next_child;
    logic              take;
    key_t              scan_key;
    logic [AW-1:0]     scan_idx;

    hdp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = key_t'(ram_rdata_raw);

    hdp_div #(
        .NW  (AW),
        .DVW (DW)
    ) u_parent_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pos_reg - AW'(1)),
        .divisor  (d_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (arity_reg < ARITY_MIN)
        begin
            d_eff = DW'(ARITY_MIN);
        end
        else if (32'(arity_reg) > MAX_ARITY)
        begin
            d_eff = DW'(MAX_ARITY);
        end
        else
        begin
            d_eff = DW'(arity_reg);
        end
    end

    assign in_ch.ready        = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.max_value   = max_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.entry_count = COUNT_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        k_next         = k_reg;
        best_key_next  = best_key_reg;
        best_idx_next  = best_idx_reg;
        slot_next      = slot_reg;
        slot_key_next  = slot_key_reg;
        upd_next       = upd_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg;
        max_next       = max_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = pos_reg;
        ram_raddr      = '0;
        ram_wdata      = cur_reg;
        div_start      = 1'b0;

        child_idx  = first_reg + FW'(k_reg);
        next_child = child_idx + FW'(1);
        take       = (k_reg == '0) || (ram_rdata > best_key_reg);
        scan_key   = take ? ram_rdata : best_key_reg;
        scan_idx   = take ? AW'(child_idx) : best_idx_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    max_next    = '0;
                    status_next = ST_OK;
                    case (in_ch.opcode)
                        OP_INSERT:
                        begin
                            if (32'(count_reg) >= CAPACITY)
                            begin
                                status_next    = ST_FULL;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                cur_next   = in_ch.item_value;
                                upd_next   = 1'b0;
                                state_next = S_UP_START;
                            end
                        end
                        OP_EXTRACT, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next    = ST_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = (in_ch.opcode == OP_PEEK) ? S_PEEK : S_EX_ROOT;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (32'(in_ch.slot_index) >= 32'(count_reg))
                            begin
                                status_next    = ST_RANGE;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                pos_next   = AW'(in_ch.slot_index);
                                slot_next  = AW'(in_ch.slot_index);
                                cur_next   = in_ch.item_value;
                                upd_next   = 1'b1;
                                moved_next = 1'b0;
                                state_next = S_DN_START;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PEEK:
            begin
                max_next       = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_EX_ROOT:
            begin
                max_next   = ram_rdata;
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(count_reg - CW'(1));
                    state_next = S_EX_LAST;
                end
            end
            S_EX_LAST:
            begin
                cur_next   = ram_rdata;
                pos_next   = '0;
                upd_next   = 1'b0;
                moved_next = 1'b0;
                state_next = S_DN_START;
            end
            S_DN_START:
            begin
                first_next = FW'(FW'(d_eff) * FW'(pos_reg) + FW'(1));
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (32'(first_reg) >= 32'(count_reg))
                begin
                    ram_we = 1'b1;
                    if (upd_reg)
                    begin
                        // sift up again from the updated slot
                        pos_next   = slot_reg;
                        cur_next   = moved_reg ? slot_key_reg : cur_reg;
                        state_next = S_UP_START;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(first_reg);
                    k_next     = '0;
                    state_next = S_DN_SCAN;
                end
            end
            S_DN_SCAN:
            begin
                // first child of the largest key wins a tie
                best_key_next = scan_key;
                best_idx_next = scan_idx;
                if ((32'(k_reg) + 1 < 32'(d_eff)) && (32'(next_child) < 32'(count_reg)))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(next_child);
                    k_next    = k_reg + DW'(1);
                end
                else
                begin
                    state_next = S_DN_DEC;
                end
            end
            S_DN_DEC:
            begin
                ram_we = 1'b1;
                if (best_key_reg > cur_reg)
                begin
                    ram_wdata  = best_key_reg;
                    pos_next   = best_idx_reg;
                    moved_next = 1'b1;
                    if (!moved_reg)
                    begin
                        slot_key_next = best_key_reg;
                    end
                    state_next = S_DN_START;
                end
                else if (upd_reg)
                begin
                    pos_next   = slot_reg;
                    cur_next   = moved_reg ? slot_key_reg : cur_reg;
                    state_next = S_UP_START;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_UP_START:
            begin
                if (pos_reg == '0)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_UP_DIV;
                end
            end
            S_UP_DIV:
            begin
                if (div_done)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = div_q;
                    best_idx_next = div_q;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cur_reg > ram_rdata)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = best_idx_reg;
                    state_next = S_UP_START;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arity_reg     <= ARITY_RESET;
            count_reg     <= '0;
            upd_reg       <= 1'b0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            max_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            upd_reg       <= upd_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            max_reg       <= max_next;
            if (cfg_we)
            begin
                arity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        first_reg    <= first_next;
        k_reg        <= k_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        slot_reg     <= slot_next;
        slot_key_reg <= slot_key_next;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hdp_pkg::*;

    localparam int HEAP_CAP   = 1024;
    localparam int ARITY_CAP  = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        key_t               max_value;
        status_t            status;
        logic [COUNT_W-1:0] entry_count;
    } heap_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ARITY_W-1:0] cfg_wdata;

    hdp_in_if  in_ch ();
    hdp_out_if out_ch ();

    d_ary_max_heap_top #(
        .CAPACITY  (HEAP_CAP),
        .MAX_ARITY (ARITY_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    key_t         heap_keys [HEAP_CAP];
    int unsigned  fill_cnt;
    int unsigned  eff_arity;
    heap_result_t pending_results[$];

    int  error_cnt;
    int  idle_cycles;
    bit  tx_gaps;
    bit  rx_gaps;
    int  rx_hold_len;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_INSERT;
        in_ch.item_value   = '0;
        in_ch.slot_index   = '0;
        out_ch.ready       = 1'b0;
    end

    function automatic void swap_slots(int a, int b);
        key_t t;
        t            = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic int sift_toward_root(int pos);
        int par;
        while (pos > 0 && pos < fill_cnt)
        begin
            par = (pos - 1) / eff_arity;
            if (!(heap_keys[pos] > heap_keys[par]))
                break;
            swap_slots(pos, par);
            pos = par;
        end
        return pos;
    endfunction

    function automatic int sift_toward_leaves(int pos);
        int first;
        int best;
        int c;
        while (pos < fill_cnt)
        begin
            first = eff_arity * pos + 1;
            if (first >= fill_cnt)
                break;
            best = first;
            for (int k = 1; k < eff_arity; k++)
            begin
                c = first + k;
                if (c >= fill_cnt)
                    break;
                if (heap_keys[c] > heap_keys[best])
                    best = c;
            end
            if (!(heap_keys[best] > heap_keys[pos]))
                break;
            swap_slots(pos, best);
            pos = best;
        end
        return pos;
    endfunction

    function automatic heap_result_t apply_heap_op(op_t op, key_t v, logic [SLOT_W-1:0] s);
        heap_result_t r;
        r.max_value = '0;
        r.status    = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (fill_cnt >= HEAP_CAP)
                    r.status = ST_FULL;
                else
                begin
                    heap_keys[fill_cnt] = v;
                    fill_cnt++;
                    void'(sift_toward_root(fill_cnt - 1));
                end
            end
            OP_EXTRACT, OP_PEEK:
            begin
                if (fill_cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.max_value = heap_keys[0];
                    if (op == OP_EXTRACT)
                    begin
                        fill_cnt--;
                        heap_keys[0] = heap_keys[fill_cnt];
                        void'(sift_toward_leaves(0));
                    end
                end
            end
            default:
            begin
                if (s >= fill_cnt)
                    r.status = ST_RANGE;
                else
                begin
                    heap_keys[s] = v;
                    void'(sift_toward_leaves(s));
                    void'(sift_toward_root(s));
                end
            end
        endcase
        r.entry_count = fill_cnt[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_cnt++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // sender: one transfer on the input channel
    task automatic send_item(op_t op, key_t v, logic [SLOT_W-1:0] s);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.opcode     = op;
        in_ch.item_value = v;
        in_ch.slot_index = s;
        in_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.insert(pending_results.size(), apply_heap_op(op, v, s));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_arity(logic [ARITY_W-1:0] d);
        wait_drained();
        cfg_wdata = d;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (d < 2)
            eff_arity = 2;
        else if (d > ARITY_CAP)
            eff_arity = ARITY_CAP;
        else
            eff_arity = d;
    endtask

    function automatic key_t pick_key();
        case ($urandom_range(0, 5))
            0:       return key_t'(32'sh8000_0000);
            1:       return key_t'(32'sh7fff_ffff);
            2, 3:    return key_t'($signed($urandom_range(0, 8)) - 4);
            default: return key_t'($urandom);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if (fill_cnt > 0 && $urandom_range(0, 9) < 8)
            return SLOT_W'($urandom_range(0, fill_cnt - 1));
        return SLOT_W'($urandom_range(0, HEAP_CAP - 1));
    endfunction

    // receiver and result check
    initial
    begin
        int n;
        heap_result_t want;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = rx_hold_len;
            if (n == 0 && rx_gaps)
                n = $urandom_range(0, 14);
            rx_hold_len = 0;
            if (n > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, entry_count", out_ch.entry_count, -1);
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.max_value !== want.max_value)
                    report_mismatch("max_value", out_ch.max_value, want.max_value);
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", out_ch.entry_count, want.entry_count);
            end
        end
    end

    // watchdog on cycles with no transfer
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else if (rst_n)
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("d_ary_max_heap_top: mismatch");
                $finish;
            end
        end
    end

    task automatic test_empty_and_edges();
        send_item(OP_EXTRACT, 32'sd5, '0);
        send_item(OP_PEEK, 32'sd0, '0);
        send_item(OP_UPDATE, 32'sd9, '0);
        send_item(OP_UPDATE, 32'sd9, {SLOT_W{1'b1}});
        send_item(OP_INSERT, key_t'(32'sh8000_0000), '0);
        send_item(OP_INSERT, key_t'(32'sh7fff_ffff), {SLOT_W{1'b1}});
        send_item(OP_INSERT, 32'sd0, '0);
        send_item(OP_INSERT, 32'sd0, '0);
        send_item(OP_INSERT, -32'sd1, '0);
        send_item(OP_PEEK, 32'sd0, '0);
        send_item(OP_UPDATE, key_t'(32'sh8000_0000), 10'd0);
        send_item(OP_UPDATE, key_t'(32'sh7fff_ffff), 10'd4);
        send_item(OP_UPDATE, 32'sd3, 10'd5);
        send_item(OP_UPDATE, 32'sd3, 10'd2);
        repeat (6)
            send_item(OP_EXTRACT, 32'sd0, '0);
        send_item(OP_PEEK, 32'sd0, '0);
    endtask

    task automatic test_full_heap();
        write_arity(4'd15);
        for (int i = 0; i < HEAP_CAP; i++)
            send_item(OP_INSERT, pick_key(), '0);
        send_item(OP_INSERT, 32'sd1, '0);
        send_item(OP_PEEK, 32'sd0, '0);
        send_item(OP_UPDATE, key_t'(32'sh7fff_ffff), 10'd1023);
        send_item(OP_UPDATE, key_t'(32'sh8000_0000), 10'd0);
        repeat (40)
            send_item(OP_EXTRACT, 32'sd0, '0);
    endtask

    task automatic test_random_mix(int items);
        int  w;
        op_t op;
        for (int i = 0; i < items; i++)
        begin
            w = $urandom_range(0, 99);
            if (fill_cnt > 60)
                w = w + 20;
            if (w < 45)
                op = OP_INSERT;
            else if (w < 70)
                op = OP_UPDATE;
            else if (w < 80)
                op = OP_PEEK;
            else
                op = OP_EXTRACT;
            send_item(op, pick_key(), pick_slot());
        end
    endtask

    task automatic test_arity_sweep();
        logic [ARITY_W-1:0] settings [12] = '{4'd0, 4'd2, 4'd3, 4'd8, 4'd1, 4'd4, 4'd5,
                                              4'd6, 4'd7, 4'd9, 4'd15, 4'd2};
        foreach (settings[k])
        begin
            write_arity(settings[k]);
            tx_gaps = (k % 4 != 2);
            rx_gaps = (k % 4 != 2);
            test_random_mix(16);
            while (fill_cnt > 0)
                send_item(OP_EXTRACT, 32'sd0, '0);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_back_pressure();
        wait_drained();
        rx_hold_len = 300;
        repeat (8)
            send_item(OP_INSERT, pick_key(), '0);
        wait_drained();
        repeat (8)
            send_item(OP_EXTRACT, 32'sd0, '0);
    endtask

    initial
    begin
        error_cnt   = 0;
        fill_cnt    = 0;
        eff_arity   = 2;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        rx_hold_len = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_and_edges();
        test_back_pressure();
        test_arity_sweep();
        test_full_heap();
        write_arity(4'd3);
        test_random_mix(60);
        wait_drained();
        repeat (200) @(negedge clk);
        if (error_cnt == 0 && pending_results.size() == 0)
            $display("d_ary_max_heap_top: match");
        else
            $display("d_ary_max_heap_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hdl/hdp_pkg.sv
hdl/hdp_in_if.sv
hdl/hdp_out_if.sv
hdl/hdp_ram.sv
hdl/hdp_div.sv
hdl/d_ary_max_heap_top.sv
verif/tb_top.sv
